// File: src/lzd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

    localparam int LANES  = 4;
    localparam int LANE_W = $clog2(LANES);

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_LIT,
        PH_OFF_HI,
        PH_OFF_LO,
        PH_LEN
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LIT,
        CMD_COPY,
        CMD_ERR
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_OFF_ZERO  = 2'd1,
        ERR_OFF_RANGE = 2'd2
    } t_err;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    // literal byte or match length in data, match distance in offset
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [15:0] offset;
        t_err        err;
    } t_cmd;

endpackage

`default_nettype wire

// File: src/lzd_history_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lzd_history_ram #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int AW            = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [HISTORY_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-first; hold the last word while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/lzd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module lzd_parser #(
    parameter int HW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_beat,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_start,
    input  wire logic [HW-1:0] i_held,
    output lzd_pkg::t_cmd      o_cmd
);
    import lzd_pkg::*;

    t_phase      r_phase, n_phase, phase_eff;
    logic [15:0] r_off, n_off;
    logic [16:0] held_eff;
    t_cmd        cmd;

    always_comb begin
        phase_eff  = i_start ? PH_FLAG : r_phase;
        held_eff   = i_start ? 17'd0 : 17'(i_held);
        n_phase    = r_phase;
        n_off      = r_off;
        cmd.kind   = CMD_NONE;
        cmd.data   = i_byte;
        cmd.offset = r_off;
        cmd.err    = ERR_OK;
        case (phase_eff)
            PH_FLAG: begin
                n_phase = (i_byte == 8'd0) ? PH_OFF_HI : PH_LIT;
            end
            PH_LIT: begin
                cmd.kind = CMD_LIT;
                n_phase  = PH_FLAG;
            end
            PH_OFF_HI: begin
                n_off   = {i_byte, 8'h00};
                n_phase = PH_OFF_LO;
            end
            PH_OFF_LO: begin
                n_off   = {r_off[15:8], i_byte};
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_phase = PH_FLAG;
                if (i_byte == 8'd0) begin
                    cmd.kind = CMD_NONE;
                end else if (r_off == 16'd0) begin
                    cmd.kind = CMD_ERR;
                    cmd.err  = ERR_OFF_ZERO;
                end else if ({1'b0, r_off} > held_eff) begin
                    cmd.kind = CMD_ERR;
                    cmd.err  = ERR_OFF_RANGE;
                end else begin
                    cmd.kind = CMD_COPY;
                end
            end
            default: begin
                n_phase = PH_FLAG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_off   <= 16'd0;
        end else if (i_beat) begin
            r_phase <= n_phase;
            r_off   <= n_off;
        end
    end

    assign o_cmd = cmd;

endmodule

`default_nettype wire

// File: src/lz77_token_decompressor.sv
// Token bytes (flag, offset, length, literal) are taken one per cycle while no match
// copy runs and the output is free; a literal beat appears in the cycle after its byte.
// A match copies one byte per cycle, while the output does not stall, through the history
// RAM (one read port, registered read, offset 1 forwarded); the input stays held from
// its length byte until the copy is done, and while a full beat waits on a stalled output.
// Reset clears the parser phase, write pointer and byte count; history RAM content is
// undefined after reset and is never read before it is written (no clearing pass).
`timescale 1ns / 1ps
`default_nettype none

module lz77_token_decompressor #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_stream_start,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_byte_0,
    output logic [7:0]      o_byte_1,
    output logic [7:0]      o_byte_2,
    output logic [7:0]      o_byte_3,
    output logic [2:0]      o_byte_count,
    output logic [1:0]      o_error_code,
    output logic            o_last_of_run
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int HW = AW + 1;
    localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [HW-1:0] FULL_HELD = HW'(HISTORY_DEPTH);

    t_state r_state, n_state;

    logic [AW-1:0] r_wp;
    logic [HW-1:0] r_held;

    logic [AW-1:0] r_src;
    logic [7:0]    r_remain;
    logic          r_one;
    logic          r_dv;
    logic          r_fwd;
    logic          r_dlast;
    logic [7:0]    r_last_wr;
    logic [7:0]    r_acc [LANES];
    logic [LANE_W-1:0] r_acc_cnt;

    logic          r_out_valid;
    logic [7:0]    r_out_b [LANES];
    logic [2:0]    r_out_cnt;
    t_err          r_out_err;
    logic          r_out_last;

    t_cmd          cmd;
    logic          in_beat, out_free;
    logic          lit_load, err_load, copy_start;
    logic          issue, d_adv, d_done, copy_load;
    logic [7:0]    mem_q, d_byte;
    logic          we;
    logic [7:0]    wdata;
    logic [16:0]   wp17, off17;
    logic [AW-1:0] src_start;
    logic [7:0]    beat_b [LANES];

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    lzd_parser #(
        .HW (HW)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (in_beat),
        .i_byte  (i_in_byte),
        .i_start (i_stream_start),
        .i_held  (r_held),
        .o_cmd   (cmd)
    );

    lzd_history_ram #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_src),
        .o_rdata (mem_q)
    );

    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = !((r_state == ST_IDLE) && out_free);
        in_beat    = i_in_valid && !o_in_stall;
        lit_load   = in_beat && (cmd.kind == CMD_LIT);
        err_load   = in_beat && (cmd.kind == CMD_ERR);
        copy_start = in_beat && (cmd.kind == CMD_COPY);

        // source address of the first copy byte, modulo the history depth
        wp17  = 17'(r_wp);
        off17 = {1'b0, cmd.offset};
        if (wp17 >= off17) begin
            src_start = AW'(wp17 - off17);
        end else begin
            src_start = AW'(wp17 + DEPTH17 - off17);
        end

        d_byte    = r_fwd ? r_last_wr : mem_q;
        d_done    = (r_acc_cnt == LANE_W'(LANES - 1)) || r_dlast;
        d_adv     = r_dv && (!d_done || out_free);
        copy_load = d_adv && d_done;
        issue     = (r_state == ST_COPY) && (r_remain != 8'd0) && (!r_dv || d_adv);

        we    = lit_load || d_adv;
        wdata = lit_load ? cmd.data : d_byte;

        for (int i = 0; i < LANES; i++) begin
            if (LANE_W'(i) < r_acc_cnt) begin
                beat_b[i] = r_acc[i];
            end else if (LANE_W'(i) == r_acc_cnt) begin
                beat_b[i] = d_byte;
            end else begin
                beat_b[i] = 8'd0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (copy_start) begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if ((r_remain == 8'd0) && !r_dv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_held <= '0;
        end else begin
            if (in_beat && i_stream_start) begin
                r_held <= '0;
            end
            if (we) begin
                r_wp <= wrap_inc(r_wp);
                if (r_held != FULL_HELD) begin
                    r_held <= r_held + HW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv      <= 1'b0;
            r_remain  <= 8'd0;
            r_acc_cnt <= '0;
        end else begin
            if (copy_start) begin
                r_remain  <= cmd.data;
                r_acc_cnt <= '0;
            end
            if (issue) begin
                r_remain <= r_remain - 8'd1;
                r_dv     <= 1'b1;
            end else if (d_adv) begin
                r_dv <= 1'b0;
            end
            if (d_adv) begin
                r_acc_cnt <= d_done ? '0 : r_acc_cnt + LANE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (copy_start) begin
            r_src <= src_start;
            r_one <= (cmd.offset == 16'd1);
        end
        if (issue) begin
            r_src   <= wrap_inc(r_src);
            // offset 1 reads the byte being written in this same cycle
            r_fwd   <= r_one && r_dv;
            r_dlast <= (r_remain == 8'd1);
        end
        if (we) begin
            r_last_wr <= wdata;
        end
        if (d_adv && !d_done) begin
            r_acc[r_acc_cnt] <= d_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (lit_load || err_load || copy_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lit_load || err_load) begin
            for (int i = 0; i < LANES; i++) begin
                r_out_b[i] <= 8'd0;
            end
            if (lit_load) begin
                r_out_b[0] <= cmd.data;
            end
            r_out_cnt  <= lit_load ? 3'd1 : 3'd0;
            r_out_err  <= lit_load ? ERR_OK : cmd.err;
            r_out_last <= 1'b1;
        end else if (copy_load) begin
            for (int i = 0; i < LANES; i++) begin
                r_out_b[i] <= beat_b[i];
            end
            r_out_cnt  <= 3'(r_acc_cnt) + 3'd1;
            r_out_err  <= ERR_OK;
            r_out_last <= r_dlast;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_0      = r_out_b[0];
    assign o_byte_1      = r_out_b[1];
    assign o_byte_2      = r_out_b[2];
    assign o_byte_3      = r_out_b[3];
    assign o_byte_count  = r_out_cnt;
    assign o_error_code  = r_out_err;
    assign o_last_of_run = r_out_last;

    a_err_beat_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_code != ERR_OK)) |-> (o_byte_count == 3'd0) && o_last_of_run)
        else $error("error beat carries bytes");

    a_copy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> o_in_stall)
        else $error("input taken during match copy");

    a_held_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= FULL_HELD)
        else $error("byte count past history depth");

    a_copy_data_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_COPY))
        else $error("copy data pending outside match copy");

endmodule

`default_nettype wire
